// ----- hdl/ffba_pkg.sv -----
package ffba_pkg;

   localparam int MAX_BLOCKS  = 16;
   localparam int MAX_ALLOCS  = 64;
   localparam int SIZE_BITS   = 16;
   localparam int BLOCK_BITS  = $clog2(MAX_BLOCKS);
   localparam int TICKET_BITS = $clog2(MAX_ALLOCS);
   localparam int COUNT_BITS  = $clog2(MAX_BLOCKS + 1);

   typedef logic [1:0]             opcode_type;
   typedef logic [1:0]             status_type;
   typedef logic [SIZE_BITS-1:0]   amount_type;
   typedef logic [TICKET_BITS-1:0] ticket_type;
   typedef logic [BLOCK_BITS-1:0]  block_type;
   typedef logic [COUNT_BITS-1:0]  count_type;

   localparam opcode_type OP_ADD     = 2'd0;
   localparam opcode_type OP_ALLOC   = 2'd1;
   localparam opcode_type OP_RELEASE = 2'd2;
   localparam opcode_type OP_NOP     = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_NO_FIT  = 2'd1;
   localparam status_type ST_UNKNOWN = 2'd2;
   localparam status_type ST_FULL    = 2'd3;

   // control from the sequencer to the allocation record table
   typedef struct packed {
      logic       read;
      logic       set;
      logic       clear;
      ticket_type addr;
      block_type  block;
      amount_type amount;
   } table_ctl_type;

endpackage

// ----- hdl/ffba_if.sv -----
interface ffba_req_if;
   logic                valid;
   logic                ready;
   ffba_pkg::opcode_type opcode;
   ffba_pkg::amount_type amount;
   ffba_pkg::ticket_type ticket_in;

   modport source (output valid, output opcode, output amount, output ticket_in,
                   input ready);
   modport sink   (input valid, input opcode, input amount, input ticket_in,
                   output ready);
endinterface

interface ffba_rsp_if;
   logic                 valid;
   logic                 ready;
   ffba_pkg::status_type status;
   ffba_pkg::ticket_type ticket_out;
   ffba_pkg::block_type  block_index;
   ffba_pkg::amount_type block_left;

   modport source (output valid, output status, output ticket_out, output block_index,
                   output block_left, input ready);
   modport sink   (input valid, input status, input ticket_out, input block_index,
                   input block_left, output ready);
endinterface

// ----- hdl/ffba_alloc_table.sv -----
module ffba_alloc_table (
   input  logic                    clock,
   input  logic                    reset,
   input  ffba_pkg::table_ctl_type ctl,
   input  ffba_pkg::ticket_type    look_addr,
   output logic                    look_valid,
   output ffba_pkg::block_type     rec_block,
   output ffba_pkg::amount_type    rec_amount
);

   logic [ffba_pkg::MAX_ALLOCS-1:0] valid_ff;
   logic [ffba_pkg::MAX_ALLOCS-1:0] valid_in;

   ffba_pkg::block_type  block_mem  [ffba_pkg::MAX_ALLOCS];
   ffba_pkg::amount_type amount_mem [ffba_pkg::MAX_ALLOCS];
   ffba_pkg::block_type  rec_block_ff;
   ffba_pkg::amount_type rec_amount_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.set) begin
         valid_in[ctl.addr] = 1'b1;
      end
      if (ctl.clear) begin
         valid_in[ctl.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // record memory, registered read
   always_ff @(posedge clock) begin
      if (ctl.set) begin
         block_mem[ctl.addr]  <= ctl.block;
         amount_mem[ctl.addr] <= ctl.amount;
      end
      if (ctl.read) begin
         rec_block_ff  <= block_mem[ctl.addr];
         rec_amount_ff <= amount_mem[ctl.addr];
      end
   end

   assign look_valid = valid_ff[look_addr];
   assign rec_block  = rec_block_ff;
   assign rec_amount = rec_amount_ff;

endmodule

// ----- hdl/first_fit_block_allocator.sv -----
// first-fit block allocator
// request channel (req_chan) carries opcode, amount and ticket_in; a transaction is
// taken when valid and ready are both high. ready is high only while the sequencer
// is idle, so one operation is worked at a time.
// response channel (rsp_chan) returns exactly one transaction per request: status,
// ticket_out, block_index and block_left, held in an output register.
// steps from request acceptance to the response, by operation:
//   add, no-op and every error found before a walk: straight to the finish state
//   release: record read, capacity read, write back
//   allocate: a walk over the blocks from block zero, 1..16 blocks walked; the
//   capacity memory has one read port, so the walk reads one block per cycle
// a new request is not taken until the last one is through; it is taken in the
// idle cycle after the result moves into the output register, which is the same
// cycle in which that response can be taken at the earliest.
// if the receiver stalls, the finished result waits in the sequencer until the
// output register frees up; a new request can be taken while the output waits.
// reset (synchronous, active high) empties the block list, clears all live
// tickets and restarts ticket numbering at zero; no memory clearing pass needed.
module first_fit_block_allocator (
   input  logic       clock,
   input  logic       reset,
   ffba_req_if.sink   req_chan,
   ffba_rsp_if.source rsp_chan
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_REL_REC = 3'd2;
   localparam logic [2:0] S_REL_CAP = 3'd3;
   localparam logic [2:0] S_FINISH  = 3'd4;

   // control state
   logic [2:0]           state_ff,       state_in;
   ffba_pkg::count_type  block_count_ff, block_count_in;
   ffba_pkg::ticket_type next_ticket_ff, next_ticket_in;
   ffba_pkg::count_type  issue_ff,       issue_in;
   logic                 rsp_valid_ff,   rsp_valid_in;

   // operation payload
   ffba_pkg::amount_type amount_ff,  amount_in;
   ffba_pkg::ticket_type ticket_ff,  ticket_in;
   ffba_pkg::block_type  cmp_idx_ff, cmp_idx_in;

   // finished result, waiting for the output register
   ffba_pkg::status_type res_status_ff, res_status_in;
   ffba_pkg::ticket_type res_ticket_ff, res_ticket_in;
   ffba_pkg::block_type  res_block_ff,  res_block_in;
   ffba_pkg::amount_type res_left_ff,   res_left_in;

   // output register
   ffba_pkg::status_type rsp_status_ff, rsp_status_in;
   ffba_pkg::ticket_type rsp_ticket_ff, rsp_ticket_in;
   ffba_pkg::block_type  rsp_block_ff,  rsp_block_in;
   ffba_pkg::amount_type rsp_left_ff,   rsp_left_in;

   // block capacity memory, one write and one registered read per cycle
   ffba_pkg::amount_type cap_mem [ffba_pkg::MAX_BLOCKS];
   ffba_pkg::amount_type cap_rdata_ff;
   ffba_pkg::block_type  cap_raddr;
   logic                 cap_we;
   ffba_pkg::block_type  cap_waddr;
   ffba_pkg::amount_type cap_wdata;

   // allocation record table
   ffba_pkg::table_ctl_type tbl_ctl;
   ffba_pkg::ticket_type    look_addr;
   logic                    look_valid;
   ffba_pkg::block_type     rec_block;
   ffba_pkg::amount_type    rec_amount;

   logic                       accept;
   logic                       out_free;
   logic                       fit;
   ffba_pkg::amount_type       fit_left;
   logic [ffba_pkg::SIZE_BITS:0] rel_sum;
   ffba_pkg::amount_type       rel_left;

   ffba_alloc_table u_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tbl_ctl),
      .look_addr  (look_addr),
      .look_valid (look_valid),
      .rec_block  (rec_block),
      .rec_amount (rec_amount)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // release looks up the named ticket, allocate checks the next ticket slot
   assign look_addr = (req_chan.opcode == ffba_pkg::OP_RELEASE) ? req_chan.ticket_in
                                                                : next_ticket_ff;

   // first-fit compare against the block read in the previous cycle
   assign fit      = (amount_ff <= cap_rdata_ff);
   assign fit_left = cap_rdata_ff - amount_ff;

   // credit with saturation at the top of the size range
   assign rel_sum  = {1'b0, cap_rdata_ff} + {1'b0, rec_amount};
   assign rel_left = rel_sum[ffba_pkg::SIZE_BITS] ? '1 : rel_sum[ffba_pkg::SIZE_BITS-1:0];

   always_comb begin
      state_in       = state_ff;
      block_count_in = block_count_ff;
      next_ticket_in = next_ticket_ff;
      issue_in       = issue_ff;
      amount_in      = amount_ff;
      ticket_in      = ticket_ff;
      cmp_idx_in     = cmp_idx_ff;
      res_status_in  = res_status_ff;
      res_ticket_in  = res_ticket_ff;
      res_block_in   = res_block_ff;
      res_left_in    = res_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_ticket_in  = rsp_ticket_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_left_in    = rsp_left_ff;

      cap_raddr      = '0;
      cap_we         = 1'b0;
      cap_waddr      = block_count_ff[ffba_pkg::BLOCK_BITS-1:0];
      cap_wdata      = req_chan.amount;

      tbl_ctl        = '0;
      tbl_ctl.addr   = look_addr;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               amount_in     = req_chan.amount;
               ticket_in     = req_chan.ticket_in;
               res_status_in = ffba_pkg::ST_OK;
               res_ticket_in = '0;
               res_block_in  = '0;
               res_left_in   = '0;
               state_in      = S_FINISH;
               unique case (req_chan.opcode)
                  ffba_pkg::OP_ADD: begin
                     if (block_count_ff == ffba_pkg::count_type'(ffba_pkg::MAX_BLOCKS)) begin
                        res_status_in = ffba_pkg::ST_FULL;
                     end else begin
                        cap_we         = 1'b1;
                        res_block_in   = block_count_ff[ffba_pkg::BLOCK_BITS-1:0];
                        res_left_in    = req_chan.amount;
                        block_count_in = block_count_ff + 1'b1;
                     end
                  end
                  ffba_pkg::OP_ALLOC: begin
                     if (look_valid) begin
                        // ticket slot still live
                        res_status_in = ffba_pkg::ST_FULL;
                        res_ticket_in = next_ticket_ff;
                     end else if (block_count_ff == '0) begin
                        res_status_in = ffba_pkg::ST_NO_FIT;
                     end else begin
                        // start the walk at block zero
                        cap_raddr  = '0;
                        cmp_idx_in = '0;
                        issue_in   = ffba_pkg::count_type'(1);
                        state_in   = S_SCAN;
                     end
                  end
                  ffba_pkg::OP_RELEASE: begin
                     if (!look_valid) begin
                        res_status_in = ffba_pkg::ST_UNKNOWN;
                        res_ticket_in = req_chan.ticket_in;
                     end else begin
                        tbl_ctl.read  = 1'b1;
                        tbl_ctl.clear = 1'b1;
                        state_in      = S_REL_REC;
                     end
                  end
                  default: begin
                     // no-op: all-zero ok result
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (fit) begin
               cap_we         = 1'b1;
               cap_waddr      = cmp_idx_ff;
               cap_wdata      = fit_left;
               tbl_ctl.set    = 1'b1;
               tbl_ctl.addr   = next_ticket_ff;
               tbl_ctl.block  = cmp_idx_ff;
               tbl_ctl.amount = amount_ff;
               next_ticket_in = (next_ticket_ff ==
                                 ffba_pkg::ticket_type'(ffba_pkg::MAX_ALLOCS - 1)) ?
                                '0 : next_ticket_ff + 1'b1;
               res_status_in  = ffba_pkg::ST_OK;
               res_ticket_in  = next_ticket_ff;
               res_block_in   = cmp_idx_ff;
               res_left_in    = fit_left;
               state_in       = S_FINISH;
            end else if (issue_ff == block_count_ff) begin
               res_status_in = ffba_pkg::ST_NO_FIT;
               state_in      = S_FINISH;
            end else begin
               // read the next block while this one was compared
               cap_raddr  = issue_ff[ffba_pkg::BLOCK_BITS-1:0];
               cmp_idx_in = issue_ff[ffba_pkg::BLOCK_BITS-1:0];
               issue_in   = issue_ff + 1'b1;
            end
         end

         S_REL_REC: begin
            cap_raddr = rec_block;
            state_in  = S_REL_CAP;
         end

         S_REL_CAP: begin
            cap_we        = 1'b1;
            cap_waddr     = rec_block;
            cap_wdata     = rel_left;
            res_status_in = ffba_pkg::ST_OK;
            res_ticket_in = ticket_ff;
            res_block_in  = rec_block;
            res_left_in   = rel_left;
            state_in      = S_FINISH;
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_ticket_in = res_ticket_ff;
               rsp_block_in  = res_block_ff;
               rsp_left_in   = res_left_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         block_count_ff <= '0;
         next_ticket_ff <= '0;
         issue_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_count_ff <= block_count_in;
         next_ticket_ff <= next_ticket_in;
         issue_ff       <= issue_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      amount_ff     <= amount_in;
      ticket_ff     <= ticket_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_ticket_ff <= res_ticket_in;
      res_block_ff  <= res_block_in;
      res_left_ff   <= res_left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ticket_ff <= rsp_ticket_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_left_ff   <= rsp_left_in;
   end

   // capacity memory; a read that shares a cycle with a write to the same entry
   // is never used, because the sequencer writes only at the end of an operation
   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_waddr] <= cap_wdata;
      end
      cap_rdata_ff <= cap_mem[cap_raddr];
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.ticket_out  = rsp_ticket_ff;
   assign rsp_chan.block_index = rsp_block_ff;
   assign rsp_chan.block_left  = rsp_left_ff;

   // block list never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      block_count_ff <= ffba_pkg::count_type'(ffba_pkg::MAX_BLOCKS))
      else $error("block count above table size");

   // the walk never reads past the filled part of the block list
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issue_ff != '0 && issue_ff <= block_count_ff))
      else $error("scan index outside block list");

   // a release of a live ticket goes on to read its record
   a_release_path: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.opcode == ffba_pkg::OP_RELEASE && look_valid)
      |=> (state_ff == S_REL_REC))
      else $error("live release did not read its record");

   // a granted allocation advances the ticket counter by one
   a_ticket_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && fit) |=> (next_ticket_ff != $past(next_ticket_ff)))
      else $error("ticket counter did not advance");

endmodule

// ----- bench/testbench.sv -----
module testbench;

   // cycles with no transaction on either channel before the run is called hung
   localparam int HANG_LIMIT = 1000;
   // settle time at the end, longer than the slowest allocate walk
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 1500;

   // one response transaction as the block should return it
   typedef struct packed {
      ffba_pkg::status_type status;
      ffba_pkg::ticket_type ticket;
      ffba_pkg::block_type  block;
      ffba_pkg::amount_type left;
   } outcome_type;

   // shadow copy of the allocator plus the queue of outcomes still owed
   class ffba_scoreboard;
      ffba_pkg::amount_type capacity [ffba_pkg::MAX_BLOCKS];
      int                   block_count;
      bit                   live [ffba_pkg::MAX_ALLOCS];
      ffba_pkg::block_type  owner [ffba_pkg::MAX_ALLOCS];
      ffba_pkg::amount_type held [ffba_pkg::MAX_ALLOCS];
      ffba_pkg::ticket_type next_ticket;
      outcome_type          expected_outcomes [$];
      int                   errors;

      function new();
         block_count = 0;
         next_ticket = '0;
         errors      = 0;
         foreach (live[i]) live[i] = 1'b0;
      endfunction

      // first-fit behavior, updates the shadow state and returns the outcome
      function outcome_type apply_request(ffba_pkg::opcode_type op,
                                          ffba_pkg::amount_type amt,
                                          ffba_pkg::ticket_type tk);
         outcome_type                  o;
         int                           b;
         ffba_pkg::block_type          blk;
         logic [ffba_pkg::SIZE_BITS:0] sum;
         o = '0;
         case (op)
            ffba_pkg::OP_ADD: begin
               if (block_count >= ffba_pkg::MAX_BLOCKS) begin
                  o.status = ffba_pkg::ST_FULL;
               end else begin
                  capacity[block_count] = amt;
                  o.block = ffba_pkg::block_type'(block_count);
                  o.left  = amt;
                  block_count++;
               end
            end
            ffba_pkg::OP_ALLOC: begin
               if (live[next_ticket]) begin
                  o.status = ffba_pkg::ST_FULL;
                  o.ticket = next_ticket;
               end else begin
                  b = 0;
                  while (b < block_count && amt > capacity[b]) b++;
                  if (b >= block_count) begin
                     o.status = ffba_pkg::ST_NO_FIT;
                  end else begin
                     capacity[b]       = capacity[b] - amt;
                     live[next_ticket]  = 1'b1;
                     owner[next_ticket] = ffba_pkg::block_type'(b);
                     held[next_ticket]  = amt;
                     o.ticket = next_ticket;
                     o.block  = ffba_pkg::block_type'(b);
                     o.left   = capacity[b];
                     next_ticket = next_ticket + 1'b1;
                  end
               end
            end
            ffba_pkg::OP_RELEASE: begin
               o.ticket = tk;
               if (!live[tk]) begin
                  o.status = ffba_pkg::ST_UNKNOWN;
               end else begin
                  blk = owner[tk];
                  sum = {1'b0, capacity[blk]} + {1'b0, held[tk]};
                  if (sum[ffba_pkg::SIZE_BITS]) capacity[blk] = '1;
                  else capacity[blk] = sum[ffba_pkg::SIZE_BITS-1:0];
                  live[tk] = 1'b0;
                  o.block  = blk;
                  o.left   = capacity[blk];
               end
            end
            default: o = '0;
         endcase
         return o;
      endfunction

      function void note_request(ffba_pkg::opcode_type op, ffba_pkg::amount_type amt,
                                 ffba_pkg::ticket_type tk);
         expected_outcomes.push_back(apply_request(op, amt, tk));
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (act !== exp) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
            errors++;
         end
      endfunction

      function void check_response(outcome_type got);
         outcome_type exp;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected response, expected none, got status %0d ticket %0d",
                     $time, got.status, got.ticket);
            errors++;
            return;
         end
         exp = expected_outcomes.pop_front();
         compare_field("status", exp.status, got.status);
         compare_field("ticket_out", exp.ticket, got.ticket);
         compare_field("block_index", exp.block, got.block);
         compare_field("block_left", exp.left, got.left);
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      function int random_live_ticket();
         int tickets [$];
         foreach (live[i]) if (live[i]) tickets.push_back(i);
         if (tickets.size() == 0) return -1;
         return tickets[$urandom_range(0, tickets.size() - 1)];
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffba_req_if req_chan ();
   ffba_rsp_if rsp_chan ();

   first_fit_block_allocator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ffba_scoreboard sb = new();

   // per-side idle ceilings
   int req_idle_max = 7;
   int rsp_idle_max = 7;
   int hang_count   = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog: any transaction on either channel resets the count
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         hang_count <= hang_count + 1;
      end
   end

   // response side: random stall, then take one transaction and check it
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, rsp_idle_max);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         sb.check_response('{rsp_chan.status, rsp_chan.ticket_out, rsp_chan.block_index,
                             rsp_chan.block_left});
      end
   end

   // one request transaction; valid stays high when the next one follows at once
   task automatic send_item(input ffba_pkg::opcode_type op, input ffba_pkg::amount_type amt,
                            input ffba_pkg::ticket_type tk);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.opcode    <= op;
      req_chan.amount    <= amt;
      req_chan.ticket_in <= tk;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(op, amt, tk);
   endtask

   // drop valid and hold off until every owed response is back
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // request sizes: mostly small so many tickets stay live, some extremes
   function automatic ffba_pkg::amount_type draw_amount();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      if (pick <= 5) return ffba_pkg::amount_type'($urandom_range(0, 255));
      if (pick <= 7) return ffba_pkg::amount_type'($urandom_range(0, 4095));
      return ffba_pkg::amount_type'($urandom);
   endfunction

   task automatic send_random(input int alloc_pct);
      int pick;
      int tk;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         send_item(ffba_pkg::OP_NOP, ffba_pkg::amount_type'($urandom),
                   ffba_pkg::ticket_type'($urandom));
      end else if (pick < 8) begin
         // block table is full by now, this keeps hitting the full case
         send_item(ffba_pkg::OP_ADD, ffba_pkg::amount_type'($urandom),
                   ffba_pkg::ticket_type'($urandom));
      end else if (pick < 8 + alloc_pct) begin
         send_item(ffba_pkg::OP_ALLOC, draw_amount(), ffba_pkg::ticket_type'($urandom));
      end else begin
         tk = sb.random_live_ticket();
         if (tk < 0 || $urandom_range(0, 99) < 15) begin
            tk = $urandom_range(0, ffba_pkg::MAX_ALLOCS - 1);
         end
         send_item(ffba_pkg::OP_RELEASE, ffba_pkg::amount_type'($urandom),
                   ffba_pkg::ticket_type'(tk));
      end
   endtask

   initial begin
      int sent;
      int chunk;
      int alloc_pct;
      ffba_pkg::amount_type caps [ffba_pkg::MAX_BLOCKS];

      req_chan.valid     <= 1'b0;
      req_chan.opcode    <= ffba_pkg::OP_NOP;
      req_chan.amount    <= '0;
      req_chan.ticket_in <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table cases first
      send_item(ffba_pkg::OP_ALLOC, '0, ffba_pkg::ticket_type'($urandom));
      send_item(ffba_pkg::OP_RELEASE, '0, '0);
      send_item(ffba_pkg::OP_RELEASE, '1, '1);
      send_item(ffba_pkg::OP_NOP, '1, '1);

      // fill the block table with extreme and mixed capacities
      caps = '{16'h0000, 16'hffff, 16'h0001, 16'd100, 16'd1000, 16'h8000, 16'h7fff,
               16'd50, 16'd200, 16'd300, 16'd5000, 16'd12345, 16'haaaa, 16'h5555,
               16'd2, 16'd40000};
      foreach (caps[i]) send_item(ffba_pkg::OP_ADD, caps[i], ffba_pkg::ticket_type'($urandom));
      // block table full
      send_item(ffba_pkg::OP_ADD, 16'd7, ffba_pkg::ticket_type'($urandom));

      // zero request lands on block 0, max request on the full-size block
      send_item(ffba_pkg::OP_ALLOC, '0, ffba_pkg::ticket_type'($urandom));
      send_item(ffba_pkg::OP_ALLOC, '1, ffba_pkg::ticket_type'($urandom));
      // nothing left big enough
      send_item(ffba_pkg::OP_ALLOC, '1, ffba_pkg::ticket_type'($urandom));
      // give the max back, then release the same ticket twice
      send_item(ffba_pkg::OP_RELEASE, '0, ffba_pkg::ticket_type'(1));
      send_item(ffba_pkg::OP_RELEASE, '0, ffba_pkg::ticket_type'(1));

      // random phases with varying mix; alloc-heavy phases wrap tickets
      // and run the ticket table full
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         chunk = $urandom_range(50, 150);
         case ($urandom_range(0, 2))
            0: alloc_pct = 30;
            1: alloc_pct = 50;
            default: alloc_pct = 80;
         endcase
         repeat (chunk) send_random(alloc_pct);
         sent += chunk;
         // let the pipeline run dry now and then
         if (sent == chunk || $urandom_range(0, 2) == 0) drain_responses();
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
